// ===== rtl/overwriting_sample_ring_window_defines.svh =====
// Assertion macros for the sample ring checker.
`ifndef OVERWRITING_SAMPLE_RING_WINDOW_DEFINES_SVH
`define OVERWRITING_SAMPLE_RING_WINDOW_DEFINES_SVH

// Checked on every clock edge outside reset.
`define OSRW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define OSRW_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/osrw_pkg.sv =====
// Shared types and constants of the sample ring window.
package osrw_pkg;

  localparam int IDX_W    = 48;
  localparam int SAMPLE_W = 16;
  localparam int CNT_W    = 7;
  localparam int FUNC_W   = 2;

  typedef enum logic [FUNC_W-1:0] {
    FN_PUSH   = 2'd0,
    FN_WINDOW = 2'd1,
    FN_TAIL   = 2'd2,
    FN_SNAP   = 2'd3
  } func_t;

  // request to the shared index adder
  typedef struct packed {
    logic             sub;
    logic [IDX_W-1:0] a;
    logic [IDX_W-1:0] b;
  } alu_req_t;

  // carry is the borrow on a subtract
  typedef struct packed {
    logic [IDX_W-1:0] res;
    logic             carry;
  } alu_rsp_t;

endpackage

// ===== rtl/osrw_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module osrw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/osrw_alu.sv =====
// Shared 48-bit index adder/subtractor used by the read sequencer.
module osrw_alu (
  input  osrw_pkg::alu_req_t req,
  output osrw_pkg::alu_rsp_t rsp
);

  logic [osrw_pkg::IDX_W:0] sum;

  always_comb begin
    if (req.sub) begin
      sum = {1'b0, req.a} - {1'b0, req.b};
    end else begin
      sum = {1'b0, req.a} + {1'b0, req.b};
    end
  end

  assign rsp.res   = sum[osrw_pkg::IDX_W-1:0];
  assign rsp.carry = sum[osrw_pkg::IDX_W];

endmodule

// ===== rtl/overwriting_sample_ring_window.sv =====
// Overwriting capture ring of 16-bit samples addressed by absolute 48-bit indices. A push may
// follow every cycle; once CAPACITY samples are held each push drops the oldest.
// A window read steps through S_LO, S_HI and S_SLOT (a tail read S_TAIL first) in the shared
// 48-bit index adder, clamping, sizing and locating the window. It then streams one word per
// cycle from the single RAM read port while out_stall is low, up to MAX_WINDOW words. An empty
// read gives its one word without a sample after the same setup; a snapshot goes straight to
// S_EMIT and gives its word from there. in_stall stays high from acceptance of a read until
// its final word has entered the output register. No clearing pass is needed.
module overwriting_sample_ring_window #(
  parameter int CAPACITY   = 4096,
  parameter int MAX_WINDOW = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [osrw_pkg::FUNC_W-1:0]    in_func,
  input  logic [osrw_pkg::SAMPLE_W-1:0]  in_sample,
  input  logic [osrw_pkg::IDX_W-1:0]     in_start_index,
  input  logic [osrw_pkg::CNT_W-1:0]     in_max_count,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [osrw_pkg::SAMPLE_W-1:0]  out_sample_out,
  output logic                           out_has_sample,
  output logic [osrw_pkg::IDX_W-1:0]     out_window_start,
  output logic [osrw_pkg::IDX_W-1:0]     out_window_next,
  output logic [osrw_pkg::IDX_W-1:0]     out_oldest_index,
  output logic                           out_clamp_flag,
  output logic                           out_exact_match,
  output logic                           out_last
);

  localparam int IW = osrw_pkg::IDX_W;
  localparam int CW = osrw_pkg::CNT_W;
  localparam int SW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int DW = $clog2(CAPACITY + 1);
  localparam int MW = (DW > CW) ? DW : CW;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_TAIL   = 7'b0000010,
    S_LO     = 7'b0000100,
    S_HI     = 7'b0001000,
    S_SLOT   = 7'b0010000,
    S_STREAM = 7'b0100000,
    S_EMIT   = 7'b1000000
  } state_t;

  state_t          state_r, state_nxt;
  logic [IW-1:0]   wc_r, wc_nxt;
  logic [IW-1:0]   oldest_r, oldest_nxt;
  logic [DW-1:0]   held_r, held_nxt;
  logic [SW-1:0]   wr_slot_r, wr_slot_nxt;
  logic [CW-1:0]   req_cnt_r, req_cnt_nxt;
  logic [IW-1:0]   start_r, start_nxt;
  logic [IW-1:0]   next_r, next_nxt;
  logic            clamped_r, clamped_nxt;
  logic            exact_r, exact_nxt;
  logic [CW-1:0]   copy_r, copy_nxt;
  logic [DW-1:0]   d_r, d_nxt;
  logic [SW-1:0]   rd_slot_r, rd_slot_nxt;
  logic [CW-1:0]   rem_r, rem_nxt;

  logic            out_valid_r, out_valid_nxt;
  logic            out_has_r, out_has_nxt;
  logic [IW-1:0]   out_ws_r, out_ws_nxt;
  logic [IW-1:0]   out_wn_r, out_wn_nxt;
  logic [IW-1:0]   out_old_r, out_old_nxt;
  logic            out_cl_r, out_cl_nxt;
  logic            out_ex_r, out_ex_nxt;
  logic            out_last_r, out_last_nxt;

  osrw_pkg::alu_req_t alu_req;
  osrw_pkg::alu_rsp_t alu_rsp;

  logic                         in_acc;
  logic                         push;
  logic                         adv;
  logic                         ram_re;
  logic [osrw_pkg::SAMPLE_W-1:0] ram_rdata;
  logic [CW-1:0]                want;
  logic [CW-1:0]                take;
  logic [CW-1:0]                copy_w;
  logic [DW:0]                  ws_ext;
  logic [DW:0]                  d_ext;
  logic [DW:0]                  slot_w;

  osrw_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  osrw_ram #(
    .WIDTH (osrw_pkg::SAMPLE_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (push),
    .waddr (wr_slot_r),
    .wdata (in_sample),
    .re    (ram_re),
    .raddr (rd_slot_r),
    .rdata (ram_rdata)
  );

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign push     = in_acc && (in_func == osrw_pkg::FN_PUSH);
  assign adv      = !out_valid_r || !out_stall;

  assign want = (req_cnt_r > CW'(MAX_WINDOW)) ? CW'(MAX_WINDOW) : req_cnt_r;
  assign take = (MW'(held_r) < MW'(req_cnt_r)) ? CW'(held_r) : req_cnt_r;
  assign copy_w = ((|alu_rsp.res[IW-1:CW]) || (alu_rsp.res[CW-1:0] >= want)) ?
                  want : alu_rsp.res[CW-1:0];

  // slot of the window start: write slot stepped back by the distance, wrapped once
  assign ws_ext = (DW+1)'(wr_slot_r);
  assign d_ext  = (DW+1)'(d_r);
  assign slot_w = (ws_ext >= d_ext) ? (ws_ext - d_ext) : (ws_ext + (DW+1)'(CAPACITY) - d_ext);

  always_comb begin
    state_nxt     = state_r;
    wc_nxt        = wc_r;
    oldest_nxt    = oldest_r;
    held_nxt      = held_r;
    wr_slot_nxt   = wr_slot_r;
    req_cnt_nxt   = req_cnt_r;
    start_nxt     = start_r;
    next_nxt      = next_r;
    clamped_nxt   = clamped_r;
    exact_nxt     = exact_r;
    copy_nxt      = copy_r;
    d_nxt         = d_r;
    rd_slot_nxt   = rd_slot_r;
    rem_nxt       = rem_r;
    out_valid_nxt = out_valid_r;
    out_has_nxt   = out_has_r;
    out_ws_nxt    = out_ws_r;
    out_wn_nxt    = out_wn_r;
    out_old_nxt   = out_old_r;
    out_cl_nxt    = out_cl_r;
    out_ex_nxt    = out_ex_r;
    out_last_nxt  = out_last_r;
    ram_re        = 1'b0;
    alu_req.sub   = 1'b1;
    alu_req.a     = start_r;
    alu_req.b     = oldest_r;

    // a word leaving with nothing behind it empties the output register
    if (adv) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          req_cnt_nxt = in_max_count;
          start_nxt   = in_start_index;
          clamped_nxt = 1'b0;
          unique case (in_func)
            osrw_pkg::FN_PUSH: begin
              wc_nxt      = wc_r + 1'b1;
              wr_slot_nxt = (wr_slot_r == SW'(CAPACITY - 1)) ? '0 : wr_slot_r + 1'b1;
              if (held_r == DW'(CAPACITY)) begin
                oldest_nxt = oldest_r + 1'b1;
              end else begin
                held_nxt = held_r + 1'b1;
              end
            end
            osrw_pkg::FN_WINDOW: state_nxt = S_LO;
            osrw_pkg::FN_TAIL:   state_nxt = S_TAIL;
            default: begin
              start_nxt = oldest_r;
              next_nxt  = wc_r;
              exact_nxt = 1'b0;
              state_nxt = S_EMIT;
            end
          endcase
        end
      end
      S_TAIL: begin
        alu_req.a = wc_r;
        alu_req.b = IW'(take);
        start_nxt = alu_rsp.res;
        state_nxt = S_LO;
      end
      S_LO: begin
        if (alu_rsp.carry) begin
          start_nxt   = oldest_r;
          clamped_nxt = 1'b1;
        end
        state_nxt = S_HI;
      end
      S_HI: begin
        alu_req.a = wc_r;
        alu_req.b = start_r;
        if (alu_rsp.carry) begin
          start_nxt   = wc_r;
          clamped_nxt = 1'b1;
          d_nxt       = '0;
          copy_nxt    = '0;
        end else begin
          d_nxt    = alu_rsp.res[DW-1:0];
          copy_nxt = copy_w;
        end
        state_nxt = S_SLOT;
      end
      S_SLOT: begin
        alu_req.sub = 1'b0;
        alu_req.a   = start_r;
        alu_req.b   = IW'(copy_r);
        next_nxt    = alu_rsp.res;
        rd_slot_nxt = SW'(slot_w);
        rem_nxt     = copy_r;
        exact_nxt   = !clamped_r && (copy_r == req_cnt_r);
        state_nxt   = (copy_r != '0) ? S_STREAM : S_EMIT;
      end
      S_STREAM: begin
        if (adv) begin
          ram_re        = 1'b1;
          rd_slot_nxt   = (rd_slot_r == SW'(CAPACITY - 1)) ? '0 : rd_slot_r + 1'b1;
          rem_nxt       = rem_r - 1'b1;
          out_valid_nxt = 1'b1;
          out_has_nxt   = 1'b1;
          out_last_nxt  = (rem_r == CW'(1));
          out_ws_nxt    = start_r;
          out_wn_nxt    = next_r;
          out_old_nxt   = oldest_r;
          out_cl_nxt    = clamped_r;
          out_ex_nxt    = exact_r;
          if (rem_r == CW'(1)) begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_EMIT: begin
        if (adv) begin
          out_valid_nxt = 1'b1;
          out_has_nxt   = 1'b0;
          out_last_nxt  = 1'b1;
          out_ws_nxt    = start_r;
          out_wn_nxt    = next_r;
          out_old_nxt   = oldest_r;
          out_cl_nxt    = clamped_r;
          out_ex_nxt    = exact_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wc_r        <= '0;
      oldest_r    <= '0;
      held_r      <= '0;
      wr_slot_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wc_r        <= wc_nxt;
      oldest_r    <= oldest_nxt;
      held_r      <= held_nxt;
      wr_slot_r   <= wr_slot_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_cnt_r  <= req_cnt_nxt;
    start_r    <= start_nxt;
    next_r     <= next_nxt;
    clamped_r  <= clamped_nxt;
    exact_r    <= exact_nxt;
    copy_r     <= copy_nxt;
    d_r        <= d_nxt;
    rd_slot_r  <= rd_slot_nxt;
    rem_r      <= rem_nxt;
    out_has_r  <= out_has_nxt;
    out_ws_r   <= out_ws_nxt;
    out_wn_r   <= out_wn_nxt;
    out_old_r  <= out_old_nxt;
    out_cl_r   <= out_cl_nxt;
    out_ex_r   <= out_ex_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_sample_out    = out_has_r ? ram_rdata : '0;
  assign out_has_sample    = out_has_r;
  assign out_window_start  = out_ws_r;
  assign out_window_next   = out_wn_r;
  assign out_oldest_index  = out_old_r;
  assign out_clamp_flag    = out_cl_r;
  assign out_exact_match   = out_ex_r;
  assign out_last          = out_last_r;

endmodule

// ===== rtl/osrw_checker.sv =====
// Port-level checker for the sample ring window, with its bind.
`include "overwriting_sample_ring_window_defines.svh"

module osrw_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [osrw_pkg::SAMPLE_W-1:0] out_sample_out,
  input logic                          out_has_sample,
  input logic [osrw_pkg::IDX_W-1:0]    out_window_start,
  input logic [osrw_pkg::IDX_W-1:0]    out_window_next,
  input logic [osrw_pkg::IDX_W-1:0]    out_oldest_index,
  input logic                          out_clamp_flag,
  input logic                          out_exact_match,
  input logic                          out_last
);

  logic [osrw_pkg::SAMPLE_W+osrw_pkg::IDX_W:0] held_word;
  logic                                        empty_ok;
  logic                                        order_ok;

  assign held_word = {out_sample_out, out_window_next, out_last};
  assign empty_ok  = out_last && (out_sample_out == '0);
  assign order_ok  = (out_window_start >= out_oldest_index) &&
                     (out_window_next >= out_window_start);

  // a stalled result word holds
  `OSRW_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(held_word), "word not held")

  // a word without a sample ends its request and carries zero
  `OSRW_ASSERT(a_empty_last, out_valid && !out_has_sample |-> empty_ok, "bad empty word")

  // window starts at or after the oldest index and next is not before the start
  `OSRW_ASSERT(a_window_order, out_valid |-> order_ok, "window indices out of order")

  // exact match never on a clamped start
  `OSRW_ASSERT(a_exact_unclamped, out_valid && out_exact_match |-> !out_clamp_flag, "exact on clamp")

endmodule

bind overwriting_sample_ring_window osrw_checker u_osrw_checker (.*);
